/* sv/mulaw_bitcrush_sample_hold_top_assert.svh */
// Assertion macros for the mu-law bit crusher block.
// Taken in by the top level; depends on nothing else.
`ifndef MULAW_BITCRUSH_SAMPLE_HOLD_TOP_ASSERT_SVH
`define MULAW_BITCRUSH_SAMPLE_HOLD_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBSH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbsh assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MBSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbsh assertion failed");

`endif

/* sv/mbsh_pkg.sv */
// Shared types and constants for the mu-law bit crusher block.
// Used by the channel interfaces, the divider and the top level.
package mbsh_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int HOLD_W     = 8;
    localparam int LEVELS_W   = 17;
    localparam int RATE_W     = 16;
    localparam int WET_W      = 17;
    localparam int CNT_W      = 9;
    localparam int V_W        = 41;
    localparam int DIV_W      = 52;
    localparam int DIVISOR_W  = 17;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 56;
    localparam int BLUR_W     = 31;

    localparam logic [BLUR_W-1:0]    GOLDEN_Q31 = 31'd1327217885;
    localparam logic [WET_W-1:0]     WET_FULL   = 17'd65536;
    // Reciprocal of 255 scaled by 2^39; exact for any 32-bit dividend.
    localparam logic [31:0]          MU_RECIP   = 32'h8080_8081;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAG,
        ST_NORM,
        ST_LOG,
        ST_KMUL,
        ST_KDIV,
        ST_DIVW1,
        ST_EXPSET,
        ST_POW,
        ST_EXPAND,
        ST_SLOPE,
        ST_BLUR,
        ST_BL1,
        ST_BL2,
        ST_BL3,
        ST_MX0,
        ST_MX1,
        ST_MX2,
        ST_DONE
    } state_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_PERIOD  = 2'd0,
        CFG_QUANT_LEVELS = 2'd1,
        CFG_RATE_SCALE   = 2'd2,
        CFG_WET_MIX      = 2'd3
    } cfg_idx_t;

    // Request to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    // Status and result of the shared divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* sv/mbsh_in_if.sv */
// Input channel: one stereo sample pair per transfer.
// Depends on mbsh_pkg for the sample width.
interface mbsh_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mbsh_pkg::SAMPLE_W-1:0] sample_left;
    logic signed [mbsh_pkg::SAMPLE_W-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

// Output channel: one processed stereo pair per transfer.
interface mbsh_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mbsh_pkg::SAMPLE_W-1:0] out_left;
    logic signed [mbsh_pkg::SAMPLE_W-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink (input valid, input out_left, input out_right, output ready);
endinterface

/* sv/mbsh_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on mbsh_pkg for the request and status structs.
module mbsh_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mbsh_pkg::div_req_t req,
    output mbsh_pkg::div_rsp_t rsp
);
    import mbsh_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    // One trial subtraction per cycle; quotient bits shift in from the right.
    always_comb
    begin
        trial     = {rem_reg, q_reg[DIV_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dsr_next  = req.divisor;
            q_next    = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
            q_next    = {q_reg[DIV_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

/* sv/mulaw_bitcrush_sample_hold_top.sv */
// Top level of the stereo mu-law bit crusher with sample and hold.
// Depends on mbsh_pkg, the channel interfaces, mbsh_div and the assertion header.
//
//  Channel     Direction  Handshake         Payload
//  sample_in   sink       valid/ready       sample_left, sample_right (s24)
//  sample_out  source     valid/ready       out_left, out_right (s24)
//  cfg         write      cfg_we            cfg_index (2), cfg_data (17)
//
// One stereo pair is processed at a time, left channel then right, through a
// shared 34x34 multiplier and a shared bit-serial divider that only divides by
// the level count (52 steps per use); division by 255 is a reciprocal multiply.
// Per channel, the exponent search settles its 31 mantissa bits one at a time.
// Reset restores the register defaults and clears all history. The input is
// ready only in the idle state; a finished pair waits in the output register,
// and a new pair may be taken while it waits.
module mulaw_bitcrush_sample_hold_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mbsh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbsh_pkg::CFG_DATA_W-1:0]  cfg_data,
    mbsh_in_if.sink                          sample_in,
    mbsh_out_if.source                       sample_out
);
    import mbsh_pkg::*;

    localparam logic signed [SAMPLE_W:0] SMAX = (SAMPLE_W+1)'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAMPLE_W:0] SMIN = -SMAX - 1;

    // Control registers.
    state_t               state_reg, state_next;
    logic                 ch_reg, ch_next;
    logic                 latch_reg, latch_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [HOLD_W-1:0]    hold_reg, hold_next;
    logic [LEVELS_W-1:0]  quant_reg, quant_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [WET_W-1:0]     wet_reg, wet_next;
    logic [5:0]           lc_reg, lc_next;
    logic                 cmp_reg, cmp_next;
    logic [4:0]           bidx_reg, bidx_next;
    logic                 out_valid_reg, out_valid_next;

    // Channel state, reset to zero.
    logic signed [SAMPLE_W-1:0] held_reg [2];
    logic signed [SAMPLE_W-1:0] held_next [2];
    logic signed [SAMPLE_W-1:0] prev_reg [2];
    logic signed [SAMPLE_W-1:0] prev_next [2];
    logic signed [SAMPLE_W-1:0] last_reg [2];
    logic signed [SAMPLE_W-1:0] last_next [2];

    // Payload registers.
    logic signed [SAMPLE_W-1:0] dry_reg [2];
    logic signed [SAMPLE_W-1:0] dry_next [2];
    logic signed [SAMPLE_W-1:0] res_reg [2];
    logic signed [SAMPLE_W-1:0] res_next [2];
    logic                       neg_reg, neg_next;
    logic [V_W-1:0]             v_reg, v_next;
    logic [3:0]                 pexp_reg, pexp_next;
    logic [31:0]                z_reg, z_next;
    logic [31:0]                f_reg, f_next;
    logic [31:0]                fr_reg, fr_next;
    logic [31:0]                t_reg, t_next;
    logic [3:0]                 ip_reg, ip_next;
    logic signed [SAMPLE_W-1:0] c_reg, c_next;
    logic [BLUR_W-1:0]          blur_reg, blur_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] blend_reg, blend_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] out_l_reg, out_l_next;
    logic signed [SAMPLE_W-1:0] out_r_reg, out_r_next;

    // Combinational helpers.
    logic                       in_xfer, out_xfer;
    logic signed [SAMPLE_W-1:0] x_cur;
    logic [SAMPLE_W-1:0]        mag;
    logic [32:0]                m_val;
    logic [V_W-1:0]             v_calc;
    logic [3:0]                 pexp_calc;
    logic                       lbit;
    logic [31:0]                zn;
    logic [5:0]                 tpos;
    logic                       tgt;
    logic                       log_done;
    logic                       log_accept;
    logic [26:0]                code;
    logic [LEVELS_W-1:0]        lv;
    logic [WET_W-1:0]           wcl;
    logic [39:0]                pw;
    logic [39:0]                pw_off;
    logic [31:0]                pw_base;
    logic [24:0]                rmag;
    logic signed [25:0]         rs;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          ad;
    logic [35:0]                slope;
    logic signed [ACC_W-1:0]    sum;
    logic signed [39:0]         mix;
    logic [31:0]                t_new;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    mbsh_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign in_xfer  = sample_in.valid && sample_in.ready;
    assign out_xfer = sample_out.valid && sample_out.ready;
    assign sample_in.ready      = (state_reg == ST_IDLE);
    assign sample_out.valid     = out_valid_reg;
    assign sample_out.out_left  = out_l_reg;
    assign sample_out.out_right = out_r_reg;

    // Shared arithmetic: magnitude, normalization, log bit, clamps.
    always_comb
    begin
        x_cur  = dry_reg[ch_reg];
        mag    = x_cur[SAMPLE_W-1] ? ($unsigned(~x_cur) + 1'b1) : $unsigned(x_cur);
        m_val  = {mag, 9'b0};
        v_calc = (V_W'(1) << 32) + {m_val, 8'b0} - {8'b0, m_val};
        pexp_calc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (v_reg[33 + i])
            begin
                pexp_calc = 4'(i + 1);
            end
        end
        lbit = prod_reg[63];
        zn   = lbit ? prod_reg[63:32] : prod_reg[62:31];
        tpos = 6'd32 - lc_reg;
        tgt  = fr_reg[tpos[4:0]];
        // In compare mode the search stops at the first bit that differs.
        log_done   = 1'b0;
        log_accept = 1'b0;
        if (lc_reg != 6'd0)
        begin
            if (cmp_reg && (lbit != tgt))
            begin
                log_done   = 1'b1;
                log_accept = tgt;
            end
            else if (lc_reg == 6'd32)
            begin
                log_done   = 1'b1;
                log_accept = 1'b1;
            end
        end
        code  = {pexp_reg, f_reg[31:9]};
        lv    = (quant_reg == '0) ? LEVELS_W'(1) : quant_reg;
        wcl   = (wet_reg > WET_FULL) ? WET_FULL : wet_reg;
        pw    = 40'(t_reg) << ip_reg;
        // The expanded value over 255 and 256 is the offset power over 256,
        // then a reciprocal multiply by 1/255.
        pw_off  = pw - 40'h00_8000_0000;
        pw_base = pw_off[39:8];
        rmag  = prod_reg[63:39];
        rs    = neg_reg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        diff  = $signed({c_reg[SAMPLE_W-1], c_reg})
              - $signed({last_reg[ch_reg][SAMPLE_W-1], last_reg[ch_reg]});
        ad    = diff[SAMPLE_W] ? $unsigned(-diff) : $unsigned(diff);
        slope = prod_reg[47:12];
        sum   = acc_reg + prod_reg[ACC_W-1:0];
        mix   = sum[55:16];
        t_new = log_accept ? z_reg : t_reg;
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LOG:
            begin
                mul_a = (lc_reg == 6'd0) ? $signed({2'b0, z_reg}) : $signed({2'b0, zn});
                mul_b = mul_a;
            end
            ST_KMUL:
            begin
                mul_a = $signed({7'b0, code});
                mul_b = $signed({17'b0, lv});
            end
            ST_POW:
            begin
                mul_a = $signed({2'b0, pw_base});
                mul_b = $signed({2'b0, MU_RECIP});
            end
            ST_SLOPE:
            begin
                mul_a = $signed({1'b0, ad, 8'b0});
                mul_b = $signed({18'b0, rate_reg});
            end
            ST_BL1:
            begin
                mul_a = MUL_W'(held_reg[ch_reg]);
                mul_b = $signed({3'b0, blur_reg});
            end
            ST_BL2:
            begin
                mul_a = MUL_W'(prev_reg[ch_reg]);
                mul_b = $signed((MUL_W'(1) << 31) - {3'b0, blur_reg});
            end
            ST_MX0:
            begin
                mul_a = MUL_W'(blend_reg);
                mul_b = $signed({17'b0, wcl});
            end
            ST_MX1:
            begin
                mul_a = MUL_W'(x_cur);
                mul_b = $signed({17'b0, WET_FULL - wcl});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p     = mul_a * mul_b;
        prod_next = mul_p[PROD_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = in_xfer ? ST_MAG : ST_IDLE;
            ST_MAG:    state_next = ST_NORM;
            ST_NORM:   state_next = ST_LOG;
            ST_LOG:
            begin
                if (log_done)
                begin
                    if (!cmp_reg)
                    begin
                        state_next = ST_KMUL;
                    end
                    else if (bidx_reg == 5'd0)
                    begin
                        state_next = ST_POW;
                    end
                end
            end
            ST_KMUL:   state_next = ST_KDIV;
            ST_KDIV:   state_next = ST_DIVW1;
            ST_DIVW1:  state_next = div_rsp.done ? ST_EXPSET : ST_DIVW1;
            ST_EXPSET: state_next = ST_LOG;
            ST_POW:    state_next = ST_EXPAND;
            ST_EXPAND: state_next = ST_SLOPE;
            ST_SLOPE:  state_next = ST_BLUR;
            ST_BLUR:   state_next = ST_BL1;
            ST_BL1:    state_next = ST_BL2;
            ST_BL2:    state_next = ST_BL3;
            ST_BL3:    state_next = ST_MX0;
            ST_MX0:    state_next = ST_MX1;
            ST_MX1:    state_next = ST_MX2;
            ST_MX2:    state_next = ch_reg ? ST_DONE : ST_MAG;
            ST_DONE:   state_next = (!out_valid_reg || sample_out.ready) ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and register updates.
    always_comb
    begin
        ch_next        = ch_reg;
        latch_next     = latch_reg;
        cnt_next       = cnt_reg;
        hold_next      = hold_reg;
        quant_next     = quant_reg;
        rate_next      = rate_reg;
        wet_next       = wet_reg;
        lc_next        = lc_reg;
        cmp_next       = cmp_reg;
        bidx_next      = bidx_reg;
        out_valid_next = out_valid_reg;
        held_next      = held_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        dry_next       = dry_reg;
        res_next       = res_reg;
        neg_next       = neg_reg;
        v_next         = v_reg;
        pexp_next      = pexp_reg;
        z_next         = z_reg;
        f_next         = f_reg;
        fr_next        = fr_reg;
        t_next         = t_reg;
        ip_next        = ip_reg;
        c_next         = c_reg;
        blur_next      = blur_reg;
        acc_next       = acc_reg;
        blend_next     = blend_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        div_req        = '0;

        // Configuration writes.
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HOLD_PERIOD:  hold_next  = cfg_data[HOLD_W-1:0];
                CFG_QUANT_LEVELS: quant_next = cfg_data[LEVELS_W-1:0];
                CFG_RATE_SCALE:   rate_next  = cfg_data[RATE_W-1:0];
                CFG_WET_MIX:      wet_next   = cfg_data[WET_W-1:0];
                default:          hold_next  = hold_reg;
            endcase
        end

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the pair and advance the hold countdown.
                if (in_xfer)
                begin
                    dry_next[0] = sample_in.sample_left;
                    dry_next[1] = sample_in.sample_right;
                    ch_next     = 1'b0;
                    latch_next  = (cnt_reg == '0);
                    if (cnt_reg == '0)
                    begin
                        cnt_next = (hold_reg == '0) ? CNT_W'(0)
                                                    : CNT_W'(hold_reg) - 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_MAG:
            begin
                neg_next = x_cur[SAMPLE_W-1];
                v_next   = v_calc;
            end
            ST_NORM:
            begin
                pexp_next = pexp_calc;
                z_next    = 32'(v_reg >> (pexp_calc + 1));
                lc_next   = '0;
                cmp_next  = 1'b0;
            end
            ST_LOG:
            begin
                // One squaring per cycle; each product yields one log bit.
                lc_next = lc_reg + 1'b1;
                if (lc_reg != 6'd0)
                begin
                    f_next = {f_reg[30:0], lbit};
                end
                if (log_done && cmp_reg)
                begin
                    t_next = t_new;
                    if (bidx_reg != 5'd0)
                    begin
                        bidx_next = bidx_reg - 1'b1;
                        z_next    = t_new | (32'd1 << (bidx_reg - 1'b1));
                        lc_next   = '0;
                    end
                end
            end
            ST_KDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {prod_reg[42:26], 3'b0, 32'b0};
                div_req.divisor  = lv;
            end
            ST_DIVW1:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient[DIV_W-1:32] > 20'd8)
                    begin
                        ip_next = 4'd8;
                        fr_next = '0;
                    end
                    else
                    begin
                        ip_next = div_rsp.quotient[35:32];
                        fr_next = div_rsp.quotient[31:0];
                    end
                end
            end
            ST_EXPSET:
            begin
                // Bit search for the largest mantissa whose log fits.
                t_next    = 32'h8000_0000;
                z_next    = 32'hC000_0000;
                bidx_next = 5'd30;
                lc_next   = '0;
                cmp_next  = 1'b1;
            end
            ST_EXPAND:
            begin
                // Apply the sign and clamp the expanded sample.
                if (rs > 26'(SMAX))
                begin
                    c_next = SMAX[SAMPLE_W-1:0];
                end
                else if (rs < 26'(SMIN))
                begin
                    c_next = SMIN[SAMPLE_W-1:0];
                end
                else
                begin
                    c_next = rs[SAMPLE_W-1:0];
                end
            end
            ST_BLUR:
            begin
                blur_next = (slope >= {5'b0, GOLDEN_Q31}) ? '0 : GOLDEN_Q31 - slope[BLUR_W-1:0];
                if (latch_reg)
                begin
                    held_next[ch_reg] = c_reg;
                end
                last_next[ch_reg] = x_cur;
            end
            ST_BL2:
            begin
                acc_next = prod_reg[ACC_W-1:0];
            end
            ST_BL3:
            begin
                blend_next        = sum[54:31];
                prev_next[ch_reg] = held_reg[ch_reg];
            end
            ST_MX1:
            begin
                acc_next = prod_reg[ACC_W-1:0];
            end
            ST_MX2:
            begin
                if (mix > 40'(SMAX))
                begin
                    res_next[ch_reg] = SMAX[SAMPLE_W-1:0];
                end
                else if (mix < 40'(SMIN))
                begin
                    res_next[ch_reg] = SMIN[SAMPLE_W-1:0];
                end
                else
                begin
                    res_next[ch_reg] = mix[SAMPLE_W-1:0];
                end
                ch_next = 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || sample_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = res_reg[0];
                    out_r_next     = res_reg[1];
                end
            end
            default:
            begin
                ch_next = ch_reg;
            end
        endcase
    end

    // Control and channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            latch_reg     <= 1'b0;
            cnt_reg       <= '0;
            hold_reg      <= HOLD_W'(1);
            quant_reg     <= LEVELS_W'(4096);
            rate_reg      <= RATE_W'(4096);
            wet_reg       <= WET_FULL;
            lc_reg        <= '0;
            cmp_reg       <= 1'b0;
            bidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            held_reg      <= '{default: '0};
            prev_reg      <= '{default: '0};
            last_reg      <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            latch_reg     <= latch_next;
            cnt_reg       <= cnt_next;
            hold_reg      <= hold_next;
            quant_reg     <= quant_next;
            rate_reg      <= rate_next;
            wet_reg       <= wet_next;
            lc_reg        <= lc_next;
            cmp_reg       <= cmp_next;
            bidx_reg      <= bidx_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            prev_reg      <= prev_next;
            last_reg      <= last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dry_reg   <= dry_next;
        res_reg   <= res_next;
        neg_reg   <= neg_next;
        v_reg     <= v_next;
        pexp_reg  <= pexp_next;
        z_reg     <= z_next;
        f_reg     <= f_next;
        fr_reg    <= fr_next;
        t_reg     <= t_next;
        ip_reg    <= ip_next;
        c_reg     <= c_next;
        blur_reg  <= blur_next;
        acc_reg   <= acc_next;
        blend_reg <= blend_next;
        prod_reg  <= prod_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
    end

    `include "mulaw_bitcrush_sample_hold_top_assert.svh"

    `MBSH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_xfer, !sample_in.ready)
    `MBSH_ASSERT_SAME(a_countdown_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(255))
    `MBSH_ASSERT_SAME(a_exp_int_range, clk, rst_n, (state_reg == ST_DIVW1) && div_rsp.done, div_rsp.quotient[DIV_W-1:32] <= 20'd8)
    `MBSH_ASSERT_SAME(a_div_free_on_start, clk, rst_n, div_req.start, !div_rsp.busy)

endmodule

/* tb/sv/tb_mulaw_bitcrush_sample_hold_top.sv */
// Self-checking testbench for the stereo mu-law bit crusher with sample and hold.
// Depends on mbsh_pkg, the channel interfaces and the top level; needs no files.
`timescale 1ns / 100ps

module tb_mulaw_bitcrush_sample_hold_top;
    import mbsh_pkg::*;

    localparam int RANDOM_ITEMS = 1530;
    localparam int MAX_PRINTS   = 40;

    // Expected stereo results, computed from an independent fixed-point model.
    class crusher_scoreboard;
        bit [63:0] hold_period, quant_levels, rate_scale, wet_mix;
        bit [63:0] countdown;
        longint held[2], prev_held[2], last_dry[2];
        longint exp_left[$], exp_right[$];

        function new();
            hold_period  = 1;
            quant_levels = 4096;
            rate_scale   = 4096;
            wet_mix      = 65536;
            countdown    = 0;
            for (int c = 0; c < 2; c++)
            begin
                held[c] = 0;
                prev_held[c] = 0;
                last_dry[c] = 0;
            end
        endfunction

        function void set_register(cfg_idx_t idx, bit [63:0] value);
            case (idx)
                CFG_HOLD_PERIOD:  hold_period  = value & 64'hFF;
                CFG_QUANT_LEVELS: quant_levels = value & 64'h1FFFF;
                CFG_RATE_SCALE:   rate_scale   = value & 64'hFFFF;
                CFG_WET_MIX:      wet_mix      = value & 64'h1FFFF;
                default: ;
            endcase
        endfunction

        function int pending();
            return exp_left.size();
        endfunction

        static function longint clamp_sample(longint v);
            if (v > 64'sd8388607)
                return 64'sd8388607;
            if (v < -64'sd8388608)
                return -64'sd8388608;
            return v;
        endfunction

        // Fraction of log2 for a Q1.31 mantissa, by repeated squaring.
        static function bit [63:0] log2_fraction(bit [63:0] z);
            bit [63:0] f;
            f = 0;
            for (int i = 0; i < 32; i++)
            begin
                z = (z * z) >> 31;
                f = f << 1;
                if (z >= (64'd1 << 32))
                begin
                    f = f | 64'd1;
                    z = z >> 1;
                end
            end
            return f;
        endfunction

        // Largest Q1.31 value whose log2 fraction does not exceed f.
        static function bit [63:0] exp2_fraction(bit [63:0] f);
            bit [63:0] t, cand;
            t = 64'd1 << 31;
            for (int b = 30; b >= 0; b--)
            begin
                cand = t | (64'd1 << b);
                if (log2_fraction(cand) <= f)
                    t = cand;
            end
            return t;
        endfunction

        // Compress, truncate to the configured levels and expand one sample.
        function longint crush_sample(longint x);
            bit neg;
            bit [63:0] mag, m, v, p, lg, code, lv, k, e8, ip, fr, pw, d;
            longint r;
            neg = x < 0;
            mag = neg ? -x : x;
            m = mag << 9;
            v = (64'd1 << 32) + 64'd255 * m;
            p = 0;
            while (p < 8 && (v >> (33 + p)) != 0)
                p++;
            lg = (p << 32) + log2_fraction(v >> (p + 1));
            code = (lg * 64'd1024) >> 19;
            lv = (quant_levels != 0) ? quant_levels : 64'd1;
            k = code * lv / (64'd1024 << 16);
            e8 = 8 * k;
            ip = e8 / lv;
            fr = ((e8 % lv) << 32) / lv;
            if (ip > 8)
            begin
                ip = 8;
                fr = 0;
            end
            pw = exp2_fraction(fr) << ip;
            d = (pw - (64'd1 << 31)) / 64'd255;
            r = longint'(d >> 8);
            return clamp_sample(neg ? -r : r);
        endfunction

        function longint run_channel(int c, longint x, bit latch);
            longint crushed, diff, blur, blend, mix, w;
            bit [63:0] ad, slope;
            crushed = crush_sample(x);
            diff = crushed - last_dry[c];
            ad = (diff < 0) ? -diff : diff;
            slope = ((ad << 8) * rate_scale) >> 12;
            blur = (slope >= GOLDEN_Q31) ? 0 : longint'(GOLDEN_Q31) - longint'(slope);
            w = (wet_mix > 65536) ? 65536 : longint'(wet_mix);
            if (latch)
                held[c] = crushed;
            last_dry[c] = x;
            blend = (held[c] * blur + prev_held[c] * ((64'sd1 <<< 31) - blur)) >>> 31;
            prev_held[c] = held[c];
            mix = (blend * w + x * (65536 - w)) >>> 16;
            return clamp_sample(mix);
        endfunction

        // Called for every accepted input pair.
        function void note_input(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
            bit latch;
            latch = countdown == 0;
            if (latch)
                countdown = (hold_period != 0) ? hold_period : 64'd1;
            exp_left.push_back(run_channel(0, longint'(l), latch));
            exp_right.push_back(run_channel(1, longint'(r), latch));
            countdown = (countdown - 1) & 64'h1FF;
        endfunction

        // Returns 0 on a match, 1 on a wrong field, 2 if nothing was expected.
        function int check_result(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                                  output logic [SAMPLE_W-1:0] el,
                                  output logic [SAMPLE_W-1:0] er);
            el = 'x;
            er = 'x;
            if (exp_left.size() == 0)
                return 2;
            el = SAMPLE_W'(exp_left.pop_front());
            er = SAMPLE_W'(exp_right.pop_front());
            return (l === el && r === er) ? 0 : 1;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mbsh_in_if  sample_in ();
    mbsh_out_if sample_out ();

    mulaw_bitcrush_sample_hold_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in.sink),
        .sample_out (sample_out.source)
    );

    crusher_scoreboard crusher = new();
    int  mismatches = 0;
    int  pairs_sent = 0;
    int  pairs_checked = 0;
    int  phases_run = 0;
    bit  idling_on = 1'b1;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(string what, logic [SAMPLE_W-1:0] gl, logic [SAMPLE_W-1:0] gr,
                          logic [SAMPLE_W-1:0] el, logic [SAMPLE_W-1:0] er);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH %s at result %0d: got %h/%h expected %h/%h",
                     what, pairs_checked, gl, gr, el, er);
    endtask

    // Input transfers feed the model.
    always @(posedge clk)
    begin
        if (rst_n && sample_in.valid && sample_in.ready)
            crusher.note_input(sample_in.sample_left, sample_in.sample_right);
    end

    // Output transfers are checked against the oldest expectation.
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] el, er;
        int status;
        if (rst_n && sample_out.valid && sample_out.ready)
        begin
            status = crusher.check_result(sample_out.out_left, sample_out.out_right, el, er);
            if (status == 2)
                report("unexpected result", sample_out.out_left, sample_out.out_right, el, er);
            else if (status == 1)
                report("wrong sample", sample_out.out_left, sample_out.out_right, el, er);
            pairs_checked++;
        end
    end

    // Receiver stalls about a quarter of the time unless idling is off.
    always @(posedge clk)
    begin
        if (!rst_n)
            sample_out.ready <= 1'b0;
        else
            sample_out.ready <= !(idling_on && $urandom_range(99) < 25);
    end

    // Write all four registers on consecutive edges while the block is idle.
    task automatic write_registers(bit [CFG_DATA_W-1:0] hold, bit [CFG_DATA_W-1:0] levels,
                                   bit [CFG_DATA_W-1:0] rate, bit [CFG_DATA_W-1:0] wet);
        bit [CFG_DATA_W-1:0] vals[4];
        cfg_idx_t idx[4];
        vals = '{hold, levels, rate, wet};
        idx = '{CFG_HOLD_PERIOD, CFG_QUANT_LEVELS, CFG_RATE_SCALE, CFG_WET_MIX};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            crusher.set_register(idx[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        phases_run++;
    endtask

    task automatic send_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
        if (idling_on && $urandom_range(99) < 25)
        begin
            sample_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_in.valid        <= 1'b1;
        sample_in.sample_left  <= l;
        sample_in.sample_right <= r;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // Lower valid and let every expected result drain.
    task automatic drain();
        sample_in.valid <= 1'b0;
        @(posedge clk);
        while (crusher.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(5))
            0:       return SAMPLE_W'(int'($urandom_range(200)) - 100);
            1:       return SAMPLE_W'(int'($urandom_range(65535)) - 32768);
            2:       return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [SAMPLE_W-1:0] dir_l[12], dir_r[12];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HOLD_PERIOD;
        cfg_data = '0;
        sample_in.valid = 1'b0;
        sample_in.sample_left = '0;
        sample_in.sample_right = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs at reset settings: extremes, full-scale negative, small steps.
        dir_l = '{0, 24'sh7FFFFF, 24'sh800000, -1, 1, 24'sh800000, 24'sh7FFFFF,
                  100, -100, 24'sh400000, 24'shC00000, 0};
        dir_r = '{0, 24'sh800000, 24'sh7FFFFF, 1, -1, 24'sh800000, 24'sh7FFFFF,
                  -100, 100, 24'shC00000, 24'sh400000, 5};
        for (int i = 0; i < 12; i++)
            send_pair(dir_l[i], dir_r[i]);
        drain();

        // Low extremes: zero period, 16 levels, zero rate, fully dry.
        write_registers(0, 16, 0, 0);
        for (int i = 0; i < 4; i++)
            send_pair(dir_l[i], dir_r[i]);
        drain();

        // High extremes, then zero levels and an oversized wet mix.
        write_registers(255, 65536, 65535, 65536);
        for (int i = 0; i < 4; i++)
            send_pair(dir_l[i], dir_r[i]);
        drain();
        write_registers(17'h1FFFF, 0, 1, 17'h1FFFF);
        for (int i = 0; i < 4; i++)
            send_pair(dir_l[i + 4], dir_r[i + 4]);
        drain();

        // Random phases with random settings; one stretch without any idling.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 170 == 0)
            begin
                drain();
                if ($urandom_range(3) == 0)
                    write_registers($urandom_range(8), $urandom_range(16, 65536),
                                    $urandom_range(65535), $urandom_range(65536));
                else
                    write_registers(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            end
            idling_on = !(n >= 500 && n < 800);
            if (n == 1100)
                drain();
            send_pair(random_sample(), random_sample());
        end
        drain();

        $display("Sent %0d stereo pairs over %0d register settings; checked %0d results.",
                 pairs_sent, phases_run, pairs_checked);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0)
            $display("tb_mulaw_bitcrush_sample_hold_top passed");
        else
            $display("tb_mulaw_bitcrush_sample_hold_top failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #200ms;
        $display("Timed out with %0d results outstanding.", crusher.pending());
        $display("tb_mulaw_bitcrush_sample_hold_top failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/mbsh_pkg.sv
sv/mbsh_in_if.sv
sv/mbsh_div.sv
sv/mulaw_bitcrush_sample_hold_top.sv
tb/sv/tb_mulaw_bitcrush_sample_hold_top.sv
